>>> rtl/ple_pkg.sv
// Shared types, codes and the microprogram of the positional list engine.
// Depends on nothing; ple_if.sv and the engine use it by scoped names, the simulation files import it.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   // Fixed field widths of the request and response words.
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;

   localparam int CAPACITY_DEF = 64;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 2'd0,
      FN_REMOVE = 2'd1,
      FN_FIND   = 2'd2,
      FN_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // Microprogram addresses.
   localparam int UPC_W = 4;
   localparam logic [UPC_W-1:0] S_INS_CHK  = 4'd0;
   localparam logic [UPC_W-1:0] S_INS_LOOP = 4'd1;
   localparam logic [UPC_W-1:0] S_INS_LAST = 4'd2;
   localparam logic [UPC_W-1:0] S_REM_CHK  = 4'd3;
   localparam logic [UPC_W-1:0] S_REM_LOOP = 4'd4;
   localparam logic [UPC_W-1:0] S_REM_LAST = 4'd5;
   localparam logic [UPC_W-1:0] S_FND_CHK  = 4'd6;
   localparam logic [UPC_W-1:0] S_FND_LOOP = 4'd7;
   localparam logic [UPC_W-1:0] S_FND_MISS = 4'd8;
   localparam logic [UPC_W-1:0] S_FND_HIT  = 4'd9;
   localparam logic [UPC_W-1:0] S_CLR      = 4'd10;

   typedef enum logic [1:0] {
      CHK_NONE = 2'd0,
      CHK_INS  = 2'd1,
      CHK_REM  = 2'd2,
      CHK_FIND = 2'd3
   } chk_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_COUNT = 3'd1,
      IDX_POS   = 3'd2,
      IDX_ZERO  = 3'd3,
      IDX_INC   = 3'd4,
      IDX_DEC   = 3'd5
   } idx_op_type;

   typedef enum logic [2:0] {
      CND_NEVER  = 3'd0,
      CND_ALWAYS = 3'd1,
      CND_AT_POS = 3'd2,
      CND_TAIL   = 3'd3,
      CND_BELOW  = 3'd4,
      CND_MATCH  = 3'd5
   } cond_type;

   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_PREV = 2'd1,
      RD_HERE = 2'd2,
      RD_NEXT = 2'd3
   } rd_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_SHIFT = 2'd1,
      WR_VALUE = 2'd2
   } wr_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2,
      CNT_ZERO = 2'd3
   } cnt_op_type;

   // One control word. Conditions other than MATCH are evaluated on the index
   // that the step computes; a taken jump discards that index.
   typedef struct packed {
      chk_type    check;
      idx_op_type idx_op;
      cond_type   jmp_cond;
      logic [UPC_W-1:0] target;
      cond_type   loop_cond;
      rd_type     rd;
      wr_type     wr;
      cnt_op_type cnt_op;
      logic       emit;
      status_type status;
      logic       idx_out;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      check: CHK_NONE, idx_op: IDX_HOLD, jmp_cond: CND_NEVER, target: S_INS_CHK,
      loop_cond: CND_NEVER, rd: RD_NONE, wr: WR_NONE, cnt_op: CNT_HOLD,
      emit: 1'b0, status: ST_OK, idx_out: 1'b0
   };

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] step);
      ucode_type w;
      w = UC_NOP;
      unique case (step)
         S_INS_CHK: begin
            w.check    = CHK_INS;
            w.idx_op   = IDX_COUNT;
            w.jmp_cond = CND_AT_POS;
            w.target   = S_INS_LAST;
            w.rd       = RD_PREV;
         end
         S_INS_LOOP: begin
            w.wr        = WR_SHIFT;
            w.idx_op    = IDX_DEC;
            w.jmp_cond  = CND_AT_POS;
            w.target    = S_INS_LAST;
            w.loop_cond = CND_ALWAYS;
            w.rd        = RD_PREV;
         end
         S_INS_LAST: begin
            w.wr     = WR_VALUE;
            w.cnt_op = CNT_INC;
            w.emit   = 1'b1;
         end
         S_REM_CHK: begin
            w.check    = CHK_REM;
            w.idx_op   = IDX_POS;
            w.jmp_cond = CND_TAIL;
            w.target   = S_REM_LAST;
            w.rd       = RD_NEXT;
         end
         S_REM_LOOP: begin
            w.wr        = WR_SHIFT;
            w.idx_op    = IDX_INC;
            w.jmp_cond  = CND_TAIL;
            w.target    = S_REM_LAST;
            w.loop_cond = CND_ALWAYS;
            w.rd        = RD_NEXT;
         end
         S_REM_LAST: begin
            w.cnt_op = CNT_DEC;
            w.emit   = 1'b1;
         end
         S_FND_CHK: begin
            w.check  = CHK_FIND;
            w.idx_op = IDX_ZERO;
            w.rd     = RD_HERE;
         end
         S_FND_LOOP: begin
            w.idx_op    = IDX_INC;
            w.jmp_cond  = CND_MATCH;
            w.target    = S_FND_HIT;
            w.loop_cond = CND_BELOW;
            w.rd        = RD_HERE;
         end
         S_FND_MISS: begin
            w.emit   = 1'b1;
            w.status = ST_MISS;
         end
         S_FND_HIT: begin
            w.emit    = 1'b1;
            w.idx_out = 1'b1;
         end
         S_CLR: begin
            w.cnt_op = CNT_ZERO;
            w.emit   = 1'b1;
         end
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] entry_step(input logic [FUNC_W-1:0] func);
      logic [UPC_W-1:0] s;
      unique case (func_type'(func))
         FN_INSERT: s = S_INS_CHK;
         FN_REMOVE: s = S_REM_CHK;
         FN_FIND:   s = S_FND_CHK;
         FN_CLEAR:  s = S_CLR;
         default:   s = S_CLR;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ple_if.sv
// Request and response channel interfaces of the positional list engine.
// Field widths come from ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ple_req_if;
   logic                                valid;
   logic                                ready;
   logic [ple_pkg::FUNC_W-1:0]          func;
   logic [ple_pkg::POS_W-1:0]           position;
   logic signed [ple_pkg::VALUE_W-1:0]  value;

   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

interface ple_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ple_pkg::STATUS_W-1:0]  status;
   logic [ple_pkg::IDX_W-1:0]     found_index;
   logic [ple_pkg::CNT_W-1:0]     count;

   modport source (output valid, status, found_index, count, input ready);
   modport sink   (input valid, status, found_index, count, output ready);
endinterface

`default_nettype wire

>>> rtl/ple_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Stands alone; holds the list entries of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/positional_list_engine.sv
// Positional list engine: microprogram sequencer and datapath over one RAM.
// Depends on ple_pkg, ple_if.sv (channel interfaces) and ple_ram.
`timescale 1ns / 1ps
`default_nettype none

// An ordered list of up to CAPACITY signed 32-bit words, held in one RAM.
// A request word is taken whenever no request is in progress, even while the
// previous response still waits in the output register. The shift and
// search loops move one entry per cycle through the single RAM read port.
// The first check of a request and the step that answers it each wait for
// as long as the previous response word has not been taken. There is no
// clearing pass after reset: only entries below the count are ever read.
module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
   localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);

   logic                            busy_ff, busy_in;
   logic [ple_pkg::UPC_W-1:0]       upc_ff, upc_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [ple_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [ple_pkg::VALUE_W-1:0]     value_ff, value_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ple_pkg::IDX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [ple_pkg::CNT_W-1:0]       rsp_count_ff, rsp_count_in;

   ple_pkg::ucode_type   w;
   ple_pkg::status_type  rej_status;
   logic                 req_accept;
   logic                 hold, reject, jump, stay, fire;
   logic [CW-1:0]        idx_next;
   logic [XW-1:0]        idx_x, cnt_x, pos_x, rd_x;
   logic                 at_pos, tail, below, match;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [ple_pkg::VALUE_W-1:0] wr_data, rd_data;

   assign w          = ple_pkg::ucode_rom(upc_ff);
   assign req_accept = req_chan.valid && !busy_ff;

   // A step that may answer waits while the output register is still full.
   assign hold = busy_ff && (w.emit || (w.check != ple_pkg::CHK_NONE)) &&
                 rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      case (w.idx_op)
         ple_pkg::IDX_COUNT: idx_next = count_ff;
         ple_pkg::IDX_POS:   idx_next = CW'(pos_ff);
         ple_pkg::IDX_ZERO:  idx_next = '0;
         ple_pkg::IDX_INC:   idx_next = idx_ff + CW'(1);
         ple_pkg::IDX_DEC:   idx_next = idx_ff - CW'(1);
         default:            idx_next = idx_ff;
      endcase
   end

   assign idx_x  = XW'(idx_next);
   assign cnt_x  = XW'(count_ff);
   assign pos_x  = XW'(pos_ff);
   assign at_pos = (idx_x == pos_x);
   assign tail   = ((idx_x + XW'(1)) >= cnt_x);
   assign below  = (idx_x < cnt_x);
   assign match  = (rd_data == value_ff);

   always_comb begin
      reject     = 1'b0;
      rej_status = ple_pkg::ST_OK;
      case (w.check)
         ple_pkg::CHK_INS: begin
            if (pos_x > cnt_x) begin
               reject     = 1'b1;
               rej_status = ple_pkg::ST_RANGE;
            end else if (count_ff >= CNT_MAX) begin
               reject     = 1'b1;
               rej_status = ple_pkg::ST_FULL;
            end
         end
         ple_pkg::CHK_REM: begin
            if (pos_x >= cnt_x) begin
               reject     = 1'b1;
               rej_status = ple_pkg::ST_RANGE;
            end
         end
         ple_pkg::CHK_FIND: begin
            if (count_ff == '0) begin
               reject     = 1'b1;
               rej_status = ple_pkg::ST_MISS;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (w.jmp_cond)
         ple_pkg::CND_ALWAYS: jump = 1'b1;
         ple_pkg::CND_AT_POS: jump = at_pos;
         ple_pkg::CND_TAIL:   jump = tail;
         ple_pkg::CND_BELOW:  jump = below;
         ple_pkg::CND_MATCH:  jump = match;
         default:             jump = 1'b0;
      endcase
      case (w.loop_cond)
         ple_pkg::CND_ALWAYS: stay = 1'b1;
         ple_pkg::CND_AT_POS: stay = at_pos;
         ple_pkg::CND_TAIL:   stay = tail;
         ple_pkg::CND_BELOW:  stay = below;
         ple_pkg::CND_MATCH:  stay = match;
         default:             stay = 1'b0;
      endcase
   end

   assign fire = busy_ff && !hold && (reject || w.emit);

   // Entry reads are issued only for addresses below the count, which also
   // drops the wrapped address before position zero.
   always_comb begin
      case (w.rd)
         ple_pkg::RD_PREV: rd_x = idx_x - XW'(1);
         ple_pkg::RD_NEXT: rd_x = idx_x + XW'(1);
         default:          rd_x = idx_x;
      endcase
   end

   assign rd_en   = busy_ff && !hold && !reject && !jump &&
                    (w.rd != ple_pkg::RD_NONE) && (rd_x < cnt_x);
   assign rd_addr = rd_x[AW-1:0];

   assign wr_en   = busy_ff && !hold && !reject && (w.wr != ple_pkg::WR_NONE);
   assign wr_addr = (w.wr == ple_pkg::WR_VALUE) ? AW'(pos_ff) : idx_ff[AW-1:0];
   assign wr_data = (w.wr == ple_pkg::WR_VALUE) ? value_ff : rd_data;

   always_comb begin
      case (w.cnt_op)
         ple_pkg::CNT_INC:  count_in = count_ff + CW'(1);
         ple_pkg::CNT_DEC:  count_in = count_ff - CW'(1);
         ple_pkg::CNT_ZERO: count_in = '0;
         default:           count_in = count_ff;
      endcase
      if (!fire || reject) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      upc_in   = upc_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      value_in = value_ff;
      if (!busy_ff) begin
         if (req_accept) begin
            busy_in  = 1'b1;
            upc_in   = ple_pkg::entry_step(req_chan.func);
            pos_in   = req_chan.position;
            value_in = $unsigned(req_chan.value);
         end
      end else if (!hold) begin
         if (reject || w.emit) begin
            busy_in = 1'b0;
         end else if (jump) begin
            upc_in = w.target;
         end else begin
            idx_in = idx_next;
            if (!stay) begin
               upc_in = upc_ff + ple_pkg::UPC_W'(1);
            end
         end
      end
   end

   assign rsp_valid_in  = fire || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_status_in = reject ? rej_status : w.status;
   assign rsp_index_in  = (w.idx_out && !reject) ? ple_pkg::IDX_W'(idx_ff) : '0;
   assign rsp_count_in  = ple_pkg::CNT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= ple_pkg::S_INS_CHK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      value_ff <= value_in;
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   ple_ram #(
      .WIDTH (ple_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready       = !busy_ff;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.count       = rsp_count_ff;

   // A request finishes only by loading a response word.
   a_done_answers: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !busy_in) |=> rsp_valid_ff)
      else $error("request finished without a response word");

   // A new response never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(rsp_valid_ff && !rsp_chan.ready))
      else $error("response word overwritten");

   // The count stays within the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above capacity");

   // Shift writes stay at or below the current count.
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (w.wr == ple_pkg::WR_SHIFT)) |-> (XW'(idx_ff) <= cnt_x))
      else $error("shift write beyond the list end");

endmodule

`default_nettype wire

>>> sim/list_scoreboard_pkg.sv
// Scoreboard for the positional list engine: a list predictor plus the queue
// of expected response words. Depends on ple_pkg for codes and field widths.
`timescale 1ns / 1ps

package list_scoreboard_pkg;
   import ple_pkg::*;

   localparam int LIST_DEPTH = CAPACITY_DEF;

   typedef struct {
      status_type        status;
      logic [IDX_W-1:0]  found_index;
      logic [CNT_W-1:0]  count;
   } response_type;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] slots[LIST_DEPTH];
      int                        length;
      response_type              awaited[$];
      int                        failures;

      function new();
         length   = 0;
         failures = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function int held();
         return length;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic signed [VALUE_W-1:0] slot(int i);
         return slots[i];
      endfunction

      // Applies one accepted request word to the list and queues its response.
      function void note_request(func_type func, logic [POS_W-1:0] position,
                                 logic signed [VALUE_W-1:0] value);
         response_type w;
         int           p;
         bit           hit;
         p             = position;
         hit           = 1'b0;
         w.status      = ST_OK;
         w.found_index = '0;
         case (func)
            FN_INSERT: begin
               // The position check wins over the full check.
               if (p > length) begin
                  w.status = ST_RANGE;
               end else if (length >= LIST_DEPTH) begin
                  w.status = ST_FULL;
               end else begin
                  for (int i = length; i > p; i--) slots[i] = slots[i-1];
                  slots[p] = value;
                  length++;
               end
            end
            FN_REMOVE: begin
               if (p >= length) begin
                  w.status = ST_RANGE;
               end else begin
                  for (int i = p; i + 1 < length; i++) slots[i] = slots[i+1];
                  length--;
               end
            end
            FN_FIND: begin
               w.status = ST_MISS;
               for (int i = 0; i < length; i++) begin
                  if (!hit && slots[i] == value) begin
                     hit           = 1'b1;
                     w.status      = ST_OK;
                     w.found_index = IDX_W'(i);
                  end
               end
            end
            default: begin
               length = 0;
            end
         endcase
         w.count = CNT_W'(length);
         awaited.push_back(w);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [IDX_W-1:0] found_index,
                                   logic [CNT_W-1:0] count);
         response_type w;
         if (awaited.size() == 0) begin
            $display("%0t: response word with none outstanding: status %0d index %0d count %0d",
                     $time, status, found_index, count);
            failures++;
            return;
         end
         w = awaited.pop_front();
         if (status !== w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, status);
            failures++;
         end
         if (found_index !== w.found_index) begin
            $display("%0t: found_index expected %0d actual %0d",
                     $time, w.found_index, found_index);
            failures++;
         end
         if (count !== w.count) begin
            $display("%0t: count expected %0d actual %0d", $time, w.count, count);
            failures++;
         end
      endfunction
   endclass

endpackage

>>> sim/testbench.sv
// Top of the positional list engine testbench: clock, reset, request and
// response drivers. Depends on ple_pkg, ple_if.sv and list_scoreboard_pkg.
`timescale 1ns / 1ps

module testbench;
   import ple_pkg::*;
   import list_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int TOTAL_WORDS   = 1150;
   localparam int SETTLE_CYCLES = 3 * CAPACITY_DEF;

   typedef enum int {
      PH_GROW   = 0,
      PH_SHRINK = 1,
      PH_MIXED  = 2
   } phase_type;

   logic           clock  = 1'b0;
   logic           reset  = 1'b1;
   bit             steady = 1'b0;
   int             cycles = 0;
   int             sent   = 0;
   list_scoreboard board;

   ple_req_if req_bus();
   ple_rsp_if rsp_bus();

   positional_list_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_response(rsp_bus.status, rsp_bus.found_index, rsp_bus.count);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(input func_type func, input logic [POS_W-1:0] position,
                            input logic signed [VALUE_W-1:0] value);
      while (!steady && $urandom_range(99) < 24) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= func;
      req_bus.position <= position;
      req_bus.value    <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(func, position, value);
      sent++;
   endtask

   // Holds the request side quiet until every outstanding response is back.
   task automatic drain();
      while (board.pending() != 0) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Small values repeat often, so finds hit and lists hold duplicates.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 40) return VALUE_W'(int'($urandom_range(15)) - 8);
      if (r < 50) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      return $urandom;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_probe();
      if (board.held() > 0 && $urandom_range(99) < 60) begin
         return board.slot($urandom_range(board.held() - 1));
      end
      return pick_value();
   endfunction

   task automatic send_random(input phase_type kind);
      int                        w_ins;
      int                        w_rem;
      int                        w_find;
      int                        r;
      int                        len;
      func_type                  func;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
      case (kind)
         PH_GROW: begin
            w_ins = 60; w_rem = 15; w_find = 23;
         end
         PH_SHRINK: begin
            w_ins = 15; w_rem = 60; w_find = 23;
         end
         default: begin
            w_ins = 34; w_rem = 30; w_find = 32;
         end
      endcase
      r   = $urandom_range(99);
      len = board.held();
      if (r < w_ins) func = FN_INSERT;
      else if (r < w_ins + w_rem) func = FN_REMOVE;
      else if (r < w_ins + w_rem + w_find) func = FN_FIND;
      else func = FN_CLEAR;
      position = POS_W'($urandom_range(127));
      if ($urandom_range(99) < 85) begin
         if (func == FN_INSERT) position = POS_W'($urandom_range(len));
         else if (func == FN_REMOVE && len > 0) position = POS_W'($urandom_range(len - 1));
      end
      value = (func == FN_FIND) ? pick_probe() : pick_value();
      send_word(func, position, value);
   endtask

   initial begin
      int        phase_no;
      int        span;
      phase_type kind;
      board            = new();
      req_bus.valid    = 1'b0;
      req_bus.func     = FN_INSERT;
      req_bus.position = '0;
      req_bus.value    = '0;
      rsp_bus.ready    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Edge cases on a short list.
      send_word(FN_FIND,   7'd0,   32'sd0);
      send_word(FN_REMOVE, 7'd0,   32'sd0);
      send_word(FN_REMOVE, 7'd127, 32'sd0);
      send_word(FN_INSERT, 7'd1,   32'sd5);
      send_word(FN_INSERT, 7'd0,   32'sh7fffffff);
      send_word(FN_INSERT, 7'd0,   32'sh80000000);
      send_word(FN_INSERT, 7'd2,   32'sd0);
      send_word(FN_INSERT, 7'd1,   -32'sd1);
      send_word(FN_INSERT, 7'd5,   32'sd9);
      send_word(FN_INSERT, 7'd127, 32'sd9);
      send_word(FN_FIND,   7'd127, 32'sh7fffffff);
      send_word(FN_INSERT, 7'd4,   -32'sd1);
      send_word(FN_FIND,   7'd0,   -32'sd1);
      send_word(FN_FIND,   7'd0,   32'sh80000000);
      send_word(FN_FIND,   7'd0,   32'sd12345);
      send_word(FN_REMOVE, 7'd4,   32'sd0);
      send_word(FN_REMOVE, 7'd4,   32'sd0);
      send_word(FN_REMOVE, 7'd0,   32'sd0);
      send_word(FN_REMOVE, 7'd1,   32'sd0);
      send_word(FN_CLEAR,  7'd127, -32'sd1);
      send_word(FN_FIND,   7'd0,   -32'sd1);
      send_word(FN_INSERT, 7'd0,   32'shaaaa5555);
      send_word(FN_REMOVE, 7'd0,   32'sd0);

      // Fill to capacity, then work the full list and its longest walks.
      while (board.held() < LIST_DEPTH) begin
         send_word(FN_INSERT, POS_W'($urandom_range(board.held())), pick_value());
      end
      send_word(FN_INSERT, 7'd64,  pick_value());
      send_word(FN_INSERT, 7'd0,   pick_value());
      send_word(FN_INSERT, 7'd65,  pick_value());
      send_word(FN_INSERT, 7'd127, pick_value());
      send_word(FN_FIND,   7'd0,   board.slot(LIST_DEPTH - 1));
      send_word(FN_FIND,   7'd0,   32'sd77777);
      send_word(FN_REMOVE, 7'd0,   32'sd0);
      send_word(FN_INSERT, 7'd0,   pick_value());
      send_word(FN_REMOVE, 7'd63,  32'sd0);
      send_word(FN_REMOVE, 7'd63,  32'sd0);
      drain();

      phase_no = 0;
      while (sent < TOTAL_WORDS) begin
         kind   = phase_type'($urandom_range(2));
         steady = (phase_no == 3);
         span   = steady ? 200 : $urandom_range(40, 160);
         for (int k = 0; k < span && sent < TOTAL_WORDS; k++) send_random(kind);
         if ($urandom_range(3) == 0) drain();
         phase_no++;
      end
      steady = 1'b0;

      drain();
      req_bus.valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_ram.sv
rtl/positional_list_engine.sv
sim/list_scoreboard_pkg.sv
sim/testbench.sv
